// File: design/fsps_pkg.sv
// Package for the fair share process scheduler: task entry type, codes and constants.
// Depends on nothing; used by the scheduler core.
package fsps_pkg;

  localparam logic [1:0] ST_UNUSED  = 2'd0;
  localparam logic [1:0] ST_SLEEP   = 2'd1;
  localparam logic [1:0] ST_RUN     = 2'd2;
  localparam logic [1:0] ST_RUNNING = 2'd3;

  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_SETN  = 3'd1;
  localparam logic [2:0] CMD_GETN  = 3'd2;
  localparam logic [2:0] CMD_PICK  = 3'd3;
  localparam logic [2:0] CMD_SLEEP = 3'd4;
  localparam logic [2:0] CMD_WAKE  = 3'd5;
  localparam logic [2:0] CMD_YIELD = 3'd6;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam logic [29:0] BILLION      = 30'd1000000000;
  localparam logic [19:0] WAKE_BIAS    = 20'd1024000;
  localparam logic [5:0]  NICE_MAX     = 6'd39;
  localparam logic [5:0]  NICE_DEFAULT = 6'd20;
  localparam logic [19:0] PERIOD_RESET = 20'd10000;
  localparam logic [19:0] TS_MAX       = 20'hFFFFF;

  typedef struct packed {
    logic [1:0]  state;
    logic [15:0] pid;
    logic [5:0]  nice;
    logic [16:0] weight;
    logic [31:0] vh;
    logic [29:0] vl;
    logic [31:0] chan;
  } fsps_entry_t;

  function automatic logic [16:0] weight_of(input logic [5:0] n);
    logic [16:0] w;
    unique case (n)
      6'd0:  w = 17'd88761;  6'd1:  w = 17'd71755;  6'd2:  w = 17'd56483;
      6'd3:  w = 17'd46273;  6'd4:  w = 17'd36291;  6'd5:  w = 17'd29154;
      6'd6:  w = 17'd23254;  6'd7:  w = 17'd18705;  6'd8:  w = 17'd14949;
      6'd9:  w = 17'd11916;  6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
      6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
      6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
      6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
      6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
      6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
      6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
      default: w = 17'd15;
    endcase
    return w;
  endfunction

endpackage

// File: design/fsps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: design/fsps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by timeslice and wake-up computations.
module fsps_div #(
  parameter int NW = 38,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNW = $clog2(NW + 1);

  logic [DW-1:0]  rem;
  logic [DW-1:0]  dvs;
  logic [CNW-1:0] cnt;
  logic [DW:0]    sh;

  assign sh = {rem, quotient[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNW'(NW);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (sh >= {1'b0, dvs}) begin
          rem      <= DW'(sh - {1'b0, dvs});
          quotient <= {quotient[NW-2:0], 1'b1};
        end else begin
          rem      <= sh[DW-1:0];
          quotient <= {quotient[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/fair_share_process_scheduler_core.sv
// Fair share process scheduler core: task table in one RAM, scanned per request.
// Each request scans the whole table; pick then divides for the timeslice, and wake scans
// the table again, dividing for each woken task when a task is runnable. One request
// at a time; a stalled result holds the core.
// Reset clears slot valid bits (unwritten slots read as unused), period 10000.
// Depends on fsps_pkg, fsps_ram and fsps_div.
module fair_share_process_scheduler_core #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] target_pid,
  input  logic [5:0]  nice_value,
  input  logic [31:0] chan_id,
  input  logic [31:0] vrt_high,
  input  logic [29:0] vrt_low,
  input  logic        inherit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  slot_out,
  output logic [15:0] pid_out,
  output logic [5:0]  nice_out,
  output logic [19:0] timeslice,
  output logic [6:0]  woken_count,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata
);
  import fsps_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int CW = AW + 1;
  localparam int TW = 17 + $clog2(TABLE_SLOTS);
  localparam int NW = 38;
  localparam int EW = $bits(fsps_entry_t);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_ACT  = 4'd2;
  localparam logic [3:0] S_PMUL = 4'd3;
  localparam logic [3:0] S_PDIV = 4'd4;
  localparam logic [3:0] S_WRD  = 4'd5;
  localparam logic [3:0] S_WCHK = 4'd6;
  localparam logic [3:0] S_WDIV = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;
  logic [19:0] slice_period;
  logic [15:0] next_pid;
  logic [TABLE_SLOTS-1:0] valid_q;

  logic [2:0]  cmd_q;
  logic [15:0] pid_q;
  logic [5:0]  nice_q;
  logic [31:0] chan_q;
  logic [31:0] vh_q;
  logic [29:0] vl_q;
  logic        inh_q;

  logic [CW-1:0] rd_idx;
  logic          pvld;
  logic [AW-1:0] pidx;

  logic          found;
  logic [AW-1:0] find_slot;
  fsps_entry_t   find_e;
  logic          free_found;
  logic [AW-1:0] free_slot;
  logic          run_any;
  logic [AW-1:0] min_slot;
  fsps_entry_t   min_e;
  logic [TW-1:0] total;
  logic [36:0]   prod;
  fsps_entry_t   cur;

  logic [1:0]  res_status;
  logic [5:0]  res_slot;
  logic [15:0] res_pid;
  logic [5:0]  res_nice;
  logic [19:0] res_ts;
  logic [6:0]  res_woken;

  logic          we;
  logic [AW-1:0] waddr;
  fsps_entry_t   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;
  fsps_entry_t   e_rd;
  logic [1:0]    act_status;
  logic          wmatch;

  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic [TW-1:0] div_divisor;
  logic          div_busy;
  logic          div_done;
  logic [NW-1:0] div_q;
  logic [19:0]   wd;

  fsps_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  fsps_div #(.NW(NW), .DW(TW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  assign in_ready = (state == S_IDLE);
  assign e_rd     = valid_q[pidx] ? fsps_entry_t'(rdata) : fsps_entry_t'('0);
  assign wmatch   = (e_rd.state == ST_SLEEP) && (e_rd.chan == chan_q);
  assign wd       = (cur.weight == 17'd0) ? WAKE_BIAS : div_q[19:0];

  always_comb begin
    we           = 1'b0;
    waddr        = find_slot;
    wdata        = find_e;
    re           = 1'b0;
    raddr        = rd_idx[AW-1:0];
    act_status   = STAT_OK;
    div_start    = 1'b0;
    div_dividend = NW'(WAKE_BIAS);
    div_divisor  = TW'(e_rd.weight);
    unique case (state)
      S_SCAN: re = (rd_idx < CW'(TABLE_SLOTS));
      S_WRD: re = (rd_idx < CW'(TABLE_SLOTS));
      S_ACT: begin
        unique case (cmd_q)
          CMD_ALLOC: begin
            if (!free_found) act_status = STAT_FULL;
            else if (inh_q && !found) act_status = STAT_NONE;
            else begin
              we          = 1'b1;
              waddr       = free_slot;
              wdata.state = ST_RUN;
              wdata.pid   = next_pid;
              wdata.chan  = '0;
              if (!inh_q) begin
                wdata.nice   = NICE_DEFAULT;
                wdata.weight = weight_of(NICE_DEFAULT);
                wdata.vh     = '0;
                wdata.vl     = '0;
              end
            end
          end
          CMD_SETN: begin
            if (nice_q > NICE_MAX) act_status = STAT_BAD;
            else if (!found) act_status = STAT_NONE;
            else begin
              we           = 1'b1;
              wdata.nice   = nice_q;
              wdata.weight = weight_of(nice_q);
            end
          end
          CMD_GETN: if (!found) act_status = STAT_NONE;
          CMD_PICK: begin
            if (!run_any) act_status = STAT_NONE;
            else begin
              we           = 1'b1;
              waddr        = min_slot;
              wdata        = min_e;
              wdata.state  = ST_RUNNING;
              wdata.weight = weight_of(min_e.nice);
            end
          end
          CMD_SLEEP: begin
            if (!found) act_status = STAT_NONE;
            else begin
              we          = 1'b1;
              wdata.state = ST_SLEEP;
              wdata.chan  = chan_q;
            end
          end
          CMD_WAKE: act_status = STAT_OK;
          CMD_YIELD: begin
            if (vl_q >= BILLION) act_status = STAT_BAD;
            else if (!found) act_status = STAT_NONE;
            else begin
              we          = 1'b1;
              wdata.state = ST_RUN;
              wdata.vh    = vh_q;
              wdata.vl    = vl_q;
            end
          end
          default: act_status = STAT_BAD;
        endcase
      end
      S_PMUL: begin
        div_start    = (total != '0);
        div_dividend = NW'(prod) + NW'(total >> 1);
        div_divisor  = total;
      end
      S_WCHK: begin
        waddr = pidx;
        wdata = e_rd;
        wdata.state = ST_RUN;
        wdata.vh = '0;
        wdata.vl = '0;
        if (wmatch) begin
          if (run_any) div_start = 1'b1;
          else we = 1'b1;
        end
      end
      S_WDIV: begin
        waddr = pidx;
        wdata = cur;
        wdata.state = ST_RUN;
        we = div_done;
        if (min_e.vl >= 30'(wd)) begin
          wdata.vh = min_e.vh;
          wdata.vl = min_e.vl - 30'(wd);
        end else if (min_e.vh != '0) begin
          wdata.vh = min_e.vh - 32'd1;
          wdata.vl = min_e.vl + (BILLION - 30'(wd));
        end else begin
          wdata.vh = '0;
          wdata.vl = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slice_period <= PERIOD_RESET;
      next_pid     <= 16'd1;
      valid_q      <= '0;
      out_valid    <= 1'b0;
      pvld         <= 1'b0;
    end else begin
      if (cfg_we) slice_period <= cfg_wdata;
      if (we) valid_q[waddr] <= 1'b1;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            pid_q      <= target_pid;
            nice_q     <= nice_value;
            chan_q     <= chan_id;
            vh_q       <= vrt_high;
            vl_q       <= vrt_low;
            inh_q      <= inherit;
            rd_idx     <= '0;
            pvld       <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            run_any    <= 1'b0;
            total      <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          pvld <= re;
          pidx <= rd_idx[AW-1:0];
          if (re) rd_idx <= rd_idx + 1'b1;
          if (pvld) begin
            if (!found && pid_q != '0 && e_rd.state != ST_UNUSED && e_rd.pid == pid_q) begin
              found     <= 1'b1;
              find_slot <= pidx;
              find_e    <= e_rd;
            end
            if (!free_found && e_rd.state == ST_UNUSED) begin
              free_found <= 1'b1;
              free_slot  <= pidx;
            end
            if (e_rd.state == ST_RUN) begin
              total <= total + TW'(e_rd.weight);
              if (!run_any || e_rd.vh < min_e.vh ||
                  (e_rd.vh == min_e.vh && e_rd.vl < min_e.vl)) begin
                run_any  <= 1'b1;
                min_slot <= pidx;
                min_e    <= e_rd;
              end
            end
            if (pidx == AW'(TABLE_SLOTS - 1)) state <= S_ACT;
          end
        end
        S_ACT: begin
          res_status <= act_status;
          res_slot   <= '0;
          res_pid    <= '0;
          res_nice   <= '0;
          res_ts     <= '0;
          res_woken  <= '0;
          state      <= S_FIN;
          if (act_status == STAT_OK) begin
            unique case (cmd_q)
              CMD_ALLOC: begin
                res_slot <= 6'(8'(free_slot));
                res_pid  <= next_pid;
                next_pid <= (next_pid == 16'hFFFF) ? 16'd1 : next_pid + 16'd1;
              end
              CMD_GETN: res_nice <= find_e.nice;
              CMD_PICK: begin
                res_slot <= 6'(8'(min_slot));
                res_pid  <= min_e.pid;
                prod     <= slice_period * weight_of(min_e.nice);
                state    <= S_PMUL;
              end
              CMD_WAKE: begin
                rd_idx <= '0;
                state  <= S_WRD;
              end
              default: ;
            endcase
          end
        end
        S_PMUL: state <= (total != '0) ? S_PDIV : S_FIN;
        S_PDIV: begin
          if (div_done) begin
            res_ts <= (div_q > NW'(TS_MAX)) ? TS_MAX : div_q[19:0];
            state  <= S_FIN;
          end
        end
        S_WRD: begin
          if (re) begin
            pidx   <= rd_idx[AW-1:0];
            rd_idx <= rd_idx + 1'b1;
            state  <= S_WCHK;
          end else begin
            state <= S_FIN;
          end
        end
        S_WCHK: begin
          cur <= e_rd;
          if (wmatch && run_any) state <= S_WDIV;
          else begin
            if (wmatch && res_woken != 7'd127) res_woken <= res_woken + 7'd1;
            state <= S_WRD;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            if (res_woken != 7'd127) res_woken <= res_woken + 7'd1;
            state <= S_WRD;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            status      <= res_status;
            slot_out    <= res_slot;
            pid_out     <= res_pid;
            nice_out    <= res_nice;
            timeslice   <= res_ts;
            woken_count <= res_woken;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_ACT || state == S_WCHK || state == S_WDIV))
    else $error("table write outside a write state");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> state == S_FIN)
    else $error("result overwrote a pending response");

endmodule
